// ===== hw/rtl/kceg_pkg.sv =====
// ----------------------------------------------------------------------------
// kceg_pkg
// Shared constants, types and key mask table for the key change event
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package kceg_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned KEY_SLOTS  = 16;
    localparam int unsigned KEY_IDX_W  = 4;
    localparam int unsigned MASK_IDX_W = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CODE_SEL_W = 3;
    localparam int unsigned NUM_CODE_REGS = 7;

    // number of scanned keys, 1 to 16
    localparam logic [5:0] NUM_KEYS = 6'd16;

    localparam logic [KEY_IDX_W-1:0] FIRST_CODED_KEY = 4'd9;
    localparam logic [KEY_IDX_W-1:0] LAST_CODED_KEY  = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_FIRE   = 3'd0,
        REG_CODE_LEFT   = 3'd1,
        REG_CODE_RIGHT  = 3'd2,
        REG_CODE_ENTER  = 3'd3,
        REG_CODE_UP     = 3'd4,
        REG_CODE_DOWN   = 3'd5,
        REG_CODE_ESCAPE = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code CODE_RESET [NUM_CODE_REGS] = '{
        8'd157, 8'd172, 8'd174, 8'd13, 8'd173, 8'd175, 8'd27
    };

    function automatic logic [WORD_W-1:0] key_mask(input logic [MASK_IDX_W-1:0] k);
        logic [WORD_W-1:0] m;
        case (k)
            5'd0:    m = 32'h0000_0400;
            5'd1:    m = 32'h0000_0800;
            5'd2:    m = 32'h0000_1000;
            5'd3:    m = 32'h0000_0100;
            5'd4:    m = 32'h0000_0200;
            5'd5:    m = 32'h0000_2000;
            5'd6:    m = 32'h8000_0000;
            5'd7:    m = 32'h2000_0000;
            5'd8:    m = 32'h0100_0000;
            5'd9:    m = 32'h1000_0000;
            5'd10:   m = 32'h4000_0000;
            5'd11:   m = 32'h0800_0000;
            5'd12:   m = 32'h0400_0000;
            5'd13:   m = 32'h0000_8000;
            5'd14:   m = 32'h0200_0000;
            5'd15:   m = 32'h0000_4000;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kceg_code_regs.sv =====
// ----------------------------------------------------------------------------
// kceg_code_regs
// Event code registers for the coded keys, written through the
// configuration port and read by the scan sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module kceg_code_regs
    import kceg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CODE_W-1:0]     i_cfg_data,
    input  wire logic [CODE_SEL_W-1:0] i_rd_sel,
    output logic      [CODE_W-1:0]     o_rd_code
);

    t_code r_code [NUM_CODE_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CODE_REGS; i++) begin
                r_code[i] <= CODE_RESET[i];
            end
        end else if (i_cfg_we && (i_cfg_index <= REG_CODE_ESCAPE)) begin
            r_code[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        if (i_rd_sel <= REG_CODE_ESCAPE) begin
            o_rd_code = r_code[i_rd_sel];
        end else begin
            o_rd_code = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/key_change_event_generator.sv =====
// ----------------------------------------------------------------------------
// key_change_event_generator
// Compares each polled keypad word with the stored pressed vector and emits
// press and release events for the coded keys, in ascending key order.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   in      | in        | i_in_valid / o_in_stall | i_raw_word
//   out     | out       | o_out_valid/ i_out_stall| o_is_release, o_key_code,
//           |           |                         | o_last_event
//   cfg     | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//
// per item, the idle state takes the word and settles the uncoded keys,
// the scan state runs coded keys 9 to 15 in turn through the single
// compare unit, and the flush state releases the held last event
// output stalls pause the scan only when an event must be pushed
// synchronous active-low reset clears the pressed vector and restores codes
// ----------------------------------------------------------------------------
`default_nettype none

module key_change_event_generator
    import kceg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [WORD_W-1:0]    i_raw_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_is_release,
    output logic      [CODE_W-1:0]    o_key_code,
    output logic                      o_last_event,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CODE_W-1:0]    i_cfg_data
);

    t_state                r_state, n_state;
    logic [KEY_IDX_W-1:0]  r_key, n_key;
    logic [WORD_W-1:0]     r_word, n_word;
    logic [KEY_SLOTS-1:0]  r_pressed, n_pressed;
    logic                  r_hold_valid, n_hold_valid;
    logic                  r_hold_rel, n_hold_rel;
    t_code                 r_hold_code, n_hold_code;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_rel, n_out_rel;
    t_code                 r_out_code, n_out_code;
    logic                  r_out_last, n_out_last;

    logic                  in_accept;
    logic                  out_free;
    logic                  key_active;
    logic                  key_now;
    logic                  key_was;
    logic                  key_evt;
    t_code                 cur_code;
    logic [CODE_SEL_W-1:0] code_sel;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign code_sel  = CODE_SEL_W'(r_key - FIRST_CODED_KEY);

    kceg_code_regs u_code_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rd_sel    (code_sel),
        .o_rd_code   (cur_code)
    );

    // shared compare unit: one key per cycle while no output stall holds the scan
    assign key_active = ({2'b00, r_key} < NUM_KEYS);
    assign key_now    = |(r_word & key_mask({1'b0, r_key}));
    assign key_was    = r_pressed[r_key];
    assign key_evt    = key_active && (key_now != key_was) && (cur_code != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pressed    <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pressed    <= n_pressed;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_word      <= n_word;
        r_hold_rel  <= n_hold_rel;
        r_hold_code <= n_hold_code;
        r_out_rel   <= n_out_rel;
        r_out_code  <= n_out_code;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_word       = r_word;
        n_pressed    = r_pressed;
        n_hold_valid = r_hold_valid;
        n_hold_rel   = r_hold_rel;
        n_hold_code  = r_hold_code;
        n_out_rel    = r_out_rel;
        n_out_code   = r_out_code;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && i_out_stall;
        o_in_stall   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_word       = i_raw_word;
                    n_key        = FIRST_CODED_KEY;
                    n_hold_valid = 1'b0;
                    // uncoded keys only track the word
                    for (int k = 0; k < FIRST_CODED_KEY; k++) begin
                        if (k < NUM_KEYS) begin
                            n_pressed[k] = |(i_raw_word & key_mask(MASK_IDX_W'(k)));
                        end
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!(key_evt && r_hold_valid && !out_free)) begin
                    if (key_active) begin
                        n_pressed[r_key] = key_now;
                    end
                    if (key_evt) begin
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_rel   = r_hold_rel;
                            n_out_code  = r_hold_code;
                            n_out_last  = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_rel   = !key_now;
                        n_hold_code  = cur_code;
                    end
                    if (r_key == LAST_CODED_KEY) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_key = r_key + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_rel    = r_hold_rel;
                    n_out_code   = r_hold_code;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_release = r_out_rel;
    assign o_key_code   = r_out_code;
    assign o_last_event = r_out_last;

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held event left over in idle");

    a_code_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_key_code != '0))
        else $error("event with zero code");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_key >= FIRST_CODED_KEY))
        else $error("scan index below coded keys");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SCAN) && (r_key == FIRST_CODED_KEY))
        else $error("scan did not start after item");
`endif

endmodule

`default_nettype wire

// ===== bench/key_change_event_generator_tb.sv =====
// ----------------------------------------------------------------------------
// key_change_event_generator_tb
// Self-checking bench for the keypad change-event generator. Polled words go
// in over the input channel with random gaps and the events come back under
// random output stalls. A scoreboard keeps its own pressed vector and code
// table, works out the press and release events of every accepted poll, and
// compares each event field by field in order. The run steps through several
// code settings written while the block is idle: reset codes, all codes at
// their maximum, a mix of silenced and extreme codes, and random codes.
// ----------------------------------------------------------------------------
module key_change_event_generator_tb
    import kceg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PCT     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NONE  = 3'd7;
    localparam logic [WORD_W-1:0]    KEY_FIELD = 32'hFF00_FF00;

    // key bit positions within the polled word, key 0 first
    localparam logic [WORD_W-1:0] KEY_BIT [KEY_SLOTS] = '{
        32'h0000_0400, 32'h0000_0800, 32'h0000_1000, 32'h0000_0100,
        32'h0000_0200, 32'h0000_2000, 32'h8000_0000, 32'h2000_0000,
        32'h0100_0000, 32'h1000_0000, 32'h4000_0000, 32'h0800_0000,
        32'h0400_0000, 32'h0000_8000, 32'h0200_0000, 32'h0000_4000
    };

    typedef struct packed {
        logic  is_release;
        t_code code;
        logic  is_last;
    } t_key_event;

    class key_event_board;
        t_code                codes [NUM_CODE_REGS];
        logic [KEY_SLOTS-1:0] held;
        t_key_event           due_q [$];
        int                   mismatches;
        int                   polls;
        int                   presses;
        int                   releases;

        function new();
            held = '0;
            foreach (codes[i]) codes[i] = CODE_RESET[i];
            mismatches = 0;
            polls      = 0;
            presses    = 0;
            releases   = 0;
        endfunction

        function void set_code(input logic [CFG_IDX_W-1:0] idx, input t_code value);
            if (idx < NUM_CODE_REGS) begin
                codes[idx] = value;
            end
        endfunction

        function void note_word(input logic [WORD_W-1:0] word);
            logic       down;
            int         n;
            t_key_event ev;
            n = 0;
            polls++;
            for (int k = 0; k < KEY_SLOTS; k++) begin
                down = (word & KEY_BIT[k]) != '0;
                if (down != held[k]) begin
                    held[k] = down;
                    if (k >= FIRST_CODED_KEY && codes[k - FIRST_CODED_KEY] != '0) begin
                        ev.is_release = !down;
                        ev.code       = codes[k - FIRST_CODED_KEY];
                        ev.is_last    = 1'b0;
                        due_q.push_back(ev);
                        n++;
                    end
                end
            end
            if (n > 0) begin
                ev = due_q.pop_back();
                ev.is_last = 1'b1;
                due_q.push_back(ev);
            end
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= 40) begin
                $display("mismatch at %0t: %s", $time, msg);
            end
        endtask

        task check_event(input logic rel, input t_code code, input logic last_ev);
            t_key_event want;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected event release=%0b code=%0d last=%0b",
                                 rel, code, last_ev));
            end else begin
                want = due_q.pop_front();
                if (rel !== want.is_release) begin
                    report($sformatf("is_release %0b, want %0b (code %0d)",
                                     rel, want.is_release, want.code));
                end
                if (code !== want.code) begin
                    report($sformatf("key_code %0d, want %0d", code, want.code));
                end
                if (last_ev !== want.is_last) begin
                    report($sformatf("last_event %0b, want %0b (code %0d)",
                                     last_ev, want.is_last, want.code));
                end
                if (want.is_release) releases++;
                else presses++;
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [WORD_W-1:0]    i_raw_word  = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    t_code                i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_is_release;
    t_code                o_key_code;
    logic                 o_last_event;

    key_event_board    board         = new();
    int                in_gap_pct    = IDLE_PCT;
    int                out_stall_pct = IDLE_PCT;
    int                quiet_cycles  = 0;
    logic [WORD_W-1:0] last_word     = '0;
    t_code             plan [NUM_CODE_REGS];

    key_change_event_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_raw_word   (i_raw_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_is_release (o_is_release),
        .o_key_code   (o_key_code),
        .o_last_event (o_last_event),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99, 0) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                board.check_event(o_is_release, o_key_code, o_last_event);
            end
            if (i_in_valid && !o_in_stall) begin
                board.note_word(i_raw_word);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("key_change_event_generator_tb: FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] word);
        while ($urandom_range(99, 0) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_word <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // wait until the last poll is scanned and all its events are out
    task automatic end_phase();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.due_q.size() != 0 || o_in_stall) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_codes(input t_code vals [NUM_CODE_REGS], input t_code stray);
        for (int i = 0; i < NUM_CODE_REGS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            board.set_code(CFG_IDX_W'(i), vals[i]);
        end
        // unused index, must leave every code alone
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_NONE;
        i_cfg_data  <= stray;
        @(posedge i_clk);
        board.set_code(REG_NONE, stray);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] next_poll(input logic [WORD_W-1:0] prev);
        logic [WORD_W-1:0] w;
        int                flips;
        w = prev;
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4, 5: begin
                flips = $urandom_range(3, 1);
                repeat (flips) w ^= KEY_BIT[$urandom_range(KEY_SLOTS - 1, 0)];
                w = (w & KEY_FIELD) | ($urandom() & ~KEY_FIELD);
            end
            6: w = $urandom();
            7: w = '0;
            8: w = ($urandom_range(1, 0) != 0) ? '1 : KEY_FIELD;
            default: w = (w & KEY_FIELD) | ($urandom() & ~KEY_FIELD);
        endcase
        return w;
    endfunction

    task automatic run_random(input int count);
        repeat (count) begin
            last_word = next_poll(last_word);
            send_word(last_word);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset codes, directed polls
        send_word('0);
        send_word('1);
        send_word('1);
        send_word('0);
        send_word(~KEY_FIELD);
        send_word(KEY_BIT[0] | KEY_BIT[1] | KEY_BIT[2] | KEY_BIT[3] | KEY_BIT[4]
                  | KEY_BIT[5] | KEY_BIT[6] | KEY_BIT[7] | KEY_BIT[8]);
        send_word('0);
        for (int k = FIRST_CODED_KEY; k < KEY_SLOTS; k++) begin
            send_word(KEY_BIT[k]);
            send_word('0);
        end
        last_word = '0;
        run_random(34);
        end_phase();

        // every code at its maximum, no idling on either side
        foreach (plan[i]) plan[i] = 8'd255;
        load_codes(plan, 8'd0);
        in_gap_pct    = 0;
        out_stall_pct = 0;
        send_word('1);
        send_word('0);
        last_word = '0;
        run_random(34);
        in_gap_pct    = IDLE_PCT;
        out_stall_pct = IDLE_PCT;
        end_phase();

        // silenced keys mixed with the smallest and largest codes
        plan[REG_CODE_FIRE]   = 8'd0;
        plan[REG_CODE_LEFT]   = 8'd1;
        plan[REG_CODE_RIGHT]  = 8'd0;
        plan[REG_CODE_ENTER]  = 8'd128;
        plan[REG_CODE_UP]     = 8'd255;
        plan[REG_CODE_DOWN]   = 8'd0;
        plan[REG_CODE_ESCAPE] = 8'd1;
        load_codes(plan, 8'd255);
        send_word('1);
        send_word('0);
        last_word = '0;
        run_random(34);
        end_phase();

        // random codes, now and then zero
        foreach (plan[i]) begin
            plan[i] = ($urandom_range(7, 0) == 0) ? 8'd0 : t_code'($urandom_range(255, 1));
        end
        load_codes(plan, t_code'($urandom_range(255, 0)));
        run_random(34);
        end_phase();

        $display("covered %0d polls and %0d events (%0d presses, %0d releases)",
                 board.polls, board.presses + board.releases, board.presses, board.releases);
        $display("code settings: reset, all maximum, silenced mix, random; plus unused index");
        if (board.mismatches == 0 && board.due_q.size() == 0) begin
            $display("key_change_event_generator_tb: PASS");
        end else begin
            $display("key_change_event_generator_tb: FAIL");
        end
        $finish;
    end

endmodule
